// File: rtl/core/hthl_pkg.sv
package hthl_pkg;

   localparam int SLOT_BITS_DEF   = 15;
   localparam int MAX_ENTRIES_DEF = 256;
   localparam int MAX_LEN_DEF     = 255;

   localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

endpackage

// File: rtl/core/header_token_hash_lookup.sv
// Channel | Ports                                          | Word
// req     | req_valid/req_ready, cmd, data_byte, last,     | one token byte
//         | entry_index                                    |
// rsp     | rsp_valid/rsp_ready, found, token_index        | one lookup result
//
// One byte per cycle while req_ready is high: the hash multiply and length
// count run in the front stage. A lookup result passes through the queue, the
// bucket read register and the compare into the output register.
// After reset a clearing pass writes every bucket, all 2**SLOT_BITS of them
// (32768 at default), with req_ready low until the pass ends.
// Token-end words wait in a four-deep queue, so rsp stalls reach req only once
// the queue fills.
module header_token_hash_lookup #(
   parameter int SLOT_BITS   = hthl_pkg::SLOT_BITS_DEF,
   parameter int MAX_ENTRIES = hthl_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_LEN     = hthl_pkg::MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic [7:0] req_entry_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_token_index
);
   import hthl_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int TOK_W = 1 + 8 + 32 + LEN_W;

   logic             tok_push;
   logic             tok_cmd;
   logic [7:0]       tok_index;
   logic [31:0]      tok_hash;
   logic [LEN_W-1:0] tok_len;
   logic             q_room;
   logic             q_valid;
   logic             q_pop;
   logic [TOK_W-1:0] q_data;
   logic             busy;

   assign req_ready = q_room && !busy;

   hthl_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_LEN     (MAX_LEN),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .req_entry_index (req_entry_index),
      .tok_push        (tok_push),
      .tok_cmd         (tok_cmd),
      .tok_index       (tok_index),
      .tok_hash        (tok_hash),
      .tok_len         (tok_len)
   );

   hthl_queue #(
      .WIDTH (TOK_W),
      .DEPTH (4)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (tok_push),
      .push_data  ({tok_cmd, tok_index, tok_hash, tok_len}),
      .room       (q_room),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   hthl_back #(
      .SLOT_BITS (SLOT_BITS),
      .MAX_LEN   (MAX_LEN),
      .LEN_W     (LEN_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_data[TOK_W-1]),
      .q_index         (q_data[LEN_W+32 +: 8]),
      .q_hash          (q_data[LEN_W +: 32]),
      .q_len           (q_data[LEN_W-1:0]),
      .q_pop           (q_pop),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_token_index (rsp_token_index)
   );

endmodule

// File: rtl/core/hthl_front.sv
module hthl_front #(
   parameter int MAX_ENTRIES = hthl_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_LEN     = hthl_pkg::MAX_LEN_DEF,
   parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_cmd,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   input  logic [7:0]        req_entry_index,
   output logic              tok_push,
   output logic              tok_cmd,
   output logic [7:0]        tok_index,
   output logic [31:0]       tok_hash,
   output logic [LEN_W-1:0]  tok_len
);
   import hthl_pkg::*;

   logic [31:0]      hash_ff, hash_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       folded;
   logic [31:0]      h_next;
   logic [LEN_W-1:0] len_next;
   logic             accept;
   logic             idx_ok;

   assign accept = req_valid && req_ready;

   // ASCII lower case to upper case
   assign folded = (req_data_byte >= 8'h61 && req_data_byte <= 8'h7a)
                   ? req_data_byte - 8'h20 : req_data_byte;

   assign h_next   = (hash_ff ^ {24'h0, folded}) * FNV_PRIME;
   assign len_next = (cnt_ff == LEN_W'(MAX_LEN)) ? cnt_ff : cnt_ff + 1'b1;
   assign idx_ok   = {24'h0, req_entry_index} < 32'(MAX_ENTRIES);

   // out-of-range inserts are dropped here, they never reach the store
   assign tok_push  = accept && req_last
                      && (cmd_type'(req_cmd) == CMD_LOOKUP || idx_ok);
   assign tok_cmd   = req_cmd;
   assign tok_index = req_entry_index;
   assign tok_hash  = h_next;
   assign tok_len   = len_next;

   always_comb begin
      hash_in = hash_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (req_last) begin
            hash_in = FNV_BASIS;
            cnt_in  = '0;
         end else begin
            hash_in = h_next;
            cnt_in  = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         cnt_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: rtl/core/hthl_queue.sv
module hthl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             room,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign room       = cnt_ff != CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/hthl_back.sv
module hthl_back #(
   parameter int SLOT_BITS = hthl_pkg::SLOT_BITS_DEF,
   parameter int MAX_LEN   = hthl_pkg::MAX_LEN_DEF,
   parameter int LEN_W     = $clog2(MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  logic              q_cmd,
   input  logic [7:0]        q_index,
   input  logic [31:0]       q_hash,
   input  logic [LEN_W-1:0]  q_len,
   output logic              q_pop,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [7:0]        rsp_token_index
);
   import hthl_pkg::*;

   localparam int SLOT_CNT = 1 << SLOT_BITS;
   localparam int ENT_W    = 1 + 8 + 32 + LEN_W;
   // entry layout: {valid, index, hash, len}
   localparam int LEN_LO   = 0;
   localparam int HASH_LO  = LEN_W;
   localparam int IDX_LO   = LEN_W + 32;
   localparam int VLD_BIT  = LEN_W + 40;

   logic [ENT_W-1:0]     mem [SLOT_CNT];
   logic [ENT_W-1:0]     rd_ff;
   logic                 clearing_ff;
   logic [SLOT_BITS-1:0] clr_ff;
   logic                 s2_valid_ff;
   logic [31:0]          s2_hash_ff;
   logic [LEN_W-1:0]     s2_len_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [7:0]           rsp_index_ff;

   logic                 is_lookup;
   logic                 s2_adv;
   logic                 lk_ok;
   logic                 rd_en;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] slot;
   logic [SLOT_BITS-1:0] addr;
   logic [ENT_W-1:0]     wr_data;
   logic                 hit;

   assign is_lookup = cmd_type'(q_cmd) == CMD_LOOKUP;
   assign slot      = q_hash[SLOT_BITS-1:0] ^ q_hash[2*SLOT_BITS-1:SLOT_BITS];

   assign s2_adv = !rsp_valid_ff || rsp_ready;
   assign lk_ok  = !s2_valid_ff || s2_adv;
   // inserts only write, so they may pass a stalled lookup already read
   assign q_pop  = q_valid && !clearing_ff && (!is_lookup || lk_ok);
   assign rd_en  = q_pop && is_lookup;
   assign wr_en  = clearing_ff || (q_pop && !is_lookup);
   assign addr   = clearing_ff ? clr_ff : slot;
   assign wr_data = clearing_ff ? '0 : {1'b1, q_index, q_hash, q_len};

   assign hit = rd_ff[VLD_BIT]
                && rd_ff[HASH_LO +: 32] == s2_hash_ff
                && rd_ff[LEN_LO +: LEN_W] == s2_len_ff
                && s2_len_ff != LEN_W'(MAX_LEN);

   assign busy            = clearing_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_token_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (rd_en) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_valid_ff && s2_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s2_hash_ff <= q_hash;
         s2_len_ff  <= q_len;
      end
      if (s2_valid_ff && s2_adv) begin
         rsp_found_ff <= hit;
         rsp_index_ff <= hit ? rd_ff[IDX_LO +: 8] : 8'h00;
      end
   end

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !q_pop && !s2_valid_ff)
      else $error("queue popped during clearing pass");

   a_no_read_over_stalled_lookup: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> $stable(rd_ff) && $stable(s2_hash_ff))
      else $error("stalled lookup lost its bucket data");

   a_clear_covers_store: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(clr_ff) == '1)
      else $error("clearing pass ended early");

endmodule
